// ===== design/lob_pkg.sv =====
`default_nettype none
package lob_pkg;

  // Table sizes.
  localparam int ORDER_SLOTS = 1024;
  localparam int OIDX_W      = $clog2(ORDER_SLOTS);
  localparam int OCNT_W      = OIDX_W + 1;
  localparam int LEVEL_SLOTS = 256;
  localparam int LIDX_W      = $clog2(LEVEL_SLOTS);
  localparam int LUSED_W     = LIDX_W + 1;
  localparam int LCNT_W      = OIDX_W + 1;
  localparam int MAX_DEPTH   = 16;
  localparam int DEPTH_W     = 5;

  typedef logic [31:0] word_t;

  // Opcodes.
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_FILL   = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_SNAP   = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_OVERFILL = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_OFULL    = 3'd4;
  localparam logic [2:0] ST_LFULL    = 3'd5;

  typedef enum logic [2:0] {K_ADD, K_CANCEL, K_FILL, K_QUERY, K_SNAP, K_NOP} kind_e;

  typedef struct packed {
    kind_e               kind;
    word_t               key;
    logic                side;
    word_t               price;
    word_t               qty;
    logic [DEPTH_W-1:0]  depth;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic  used;
    word_t key;
    logic  side;
    word_t price;
    word_t size;
    word_t filled;
  } order_t;

  typedef struct packed {
    word_t              price;
    word_t              total;
    logic [LCNT_W-1:0]  count;
  } level_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OSCAN, S_ODEC, S_LSCAN, S_LDEC, S_SHIFT, S_LINS,
    S_BEST0, S_BEST1, S_BEST2, S_EMIT, S_SNAP
  } state_e;

endpackage
`default_nettype wire

// ===== design/lob_front.sv =====
`default_nettype none
module lob_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  opcode_i,
  input  wire lob_pkg::word_t              order_key_i,
  input  wire logic                        side_i,
  input  wire lob_pkg::word_t              price_i,
  input  wire lob_pkg::word_t              quantity_i,
  input  wire logic [lob_pkg::DEPTH_W-1:0] depth_i,
  output lob_pkg::cmd_t                    cmd_o,
  output logic                             cmd_valid_o,
  input  wire lob_pkg::back_stat_t         stat_i
);

  lob_pkg::cmd_t  q_mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push;
  lob_pkg::cmd_t  cls;

  // Classify the incoming word.
  always_comb begin
    cls.key   = order_key_i;
    cls.side  = side_i;
    cls.price = price_i;
    cls.qty   = quantity_i;
    cls.depth = (depth_i > lob_pkg::DEPTH_W'(lob_pkg::MAX_DEPTH)) ?
                lob_pkg::DEPTH_W'(lob_pkg::MAX_DEPTH) : depth_i;
    unique case (opcode_i)
      lob_pkg::OP_ADD:    cls.kind = lob_pkg::K_ADD;
      lob_pkg::OP_CANCEL: cls.kind = lob_pkg::K_CANCEL;
      lob_pkg::OP_FILL:   cls.kind = lob_pkg::K_FILL;
      lob_pkg::OP_QUERY:  cls.kind = lob_pkg::K_QUERY;
      lob_pkg::OP_SNAP:   cls.kind = lob_pkg::K_SNAP;
      default:            cls.kind = lob_pkg::K_NOP;
    endcase
  end

  assign busy        = (cnt_q == 2'd2) || stat_i.clearing;
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rp_q];

  // Two-entry command queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (stat_i.pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(stat_i.pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= cls;
  end

endmodule
`default_nettype wire

// ===== design/lob_back.sv =====
`default_nettype none
module lob_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lob_pkg::cmd_t          cmd_i,
  input  wire logic                   cmd_valid_i,
  output lob_pkg::back_stat_t         stat_o,
  output logic                        res_valid_o,
  output logic [2:0]                  status_o,
  output lob_pkg::word_t              best_bid_o,
  output lob_pkg::word_t              best_ask_o,
  output logic [32:0]                 mid_sum_o,
  output lob_pkg::word_t              level_quantity_o,
  output logic                        entry_valid_o,
  output lob_pkg::word_t              entry_price_o,
  output lob_pkg::word_t              entry_quantity_o,
  output logic                        last_o
);

  localparam int OW = lob_pkg::OIDX_W;
  localparam int CW = lob_pkg::OCNT_W;
  localparam int LW = lob_pkg::LIDX_W;
  localparam int UW = lob_pkg::LUSED_W;
  localparam int NW = lob_pkg::LCNT_W;

  // Memories.
  lob_pkg::order_t ord_mem [lob_pkg::ORDER_SLOTS];
  lob_pkg::level_t lvl_mem [2*lob_pkg::LEVEL_SLOTS];
  lob_pkg::order_t ord_rd_q, ow_data;
  lob_pkg::level_t lvl_rd_q, lw_data;
  logic [OW-1:0]   ord_ra, ow_addr;
  logic [LW:0]     lvl_ra, lw_addr;
  logic            ow_en, lw_en;

  lob_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q;
  logic            pv_q;
  logic [OW-1:0]   pidx_q;
  logic            issue;
  logic [OW-1:0]   issue_idx;
  logic            emit;
  logic [UW-1:0]   used_q [2];
  lob_pkg::word_t  bid_q, ask_q;
  logic            res_v_q;

  logic            hit_q, free_q, lhit_q, iset_q;
  lob_pkg::cmd_t   cmd_q;
  logic [OW-1:0]   hit_idx_q, free_idx_q;
  lob_pkg::order_t orec_q;
  logic            lside_q;
  lob_pkg::word_t  lprice_q;
  logic [LW-1:0]   lidx_q;
  lob_pkg::word_t  ltot_q;
  logic [NW-1:0]   lcnt_q;
  logic [UW-1:0]   ipos_q, n_q, mv_q, src_q;
  logic            dir_up_q;
  lob_pkg::word_t  tq_q;
  logic            drop_q;
  logic [2:0]      status_q;
  lob_pkg::word_t  lq_q;

  logic [2:0]      o_status_q;
  lob_pkg::word_t  o_bid_q, o_ask_q, o_lq_q, o_eprice_q, o_eqty_q;
  logic [32:0]     o_mid_q;
  logic            o_ev_q, o_last_q;

  // Derived values.
  logic [UW-1:0]   lused, snap_n, ins_pos;
  logic [32:0]     newf, addsum;
  logic            over, done, beats;
  lob_pkg::word_t  rem, newtot, sattot;
  logic [NW-1:0]   newcnt;

  always_comb begin
    lused   = used_q[lside_q];
    snap_n  = (UW'(cmd_i.depth) < used_q[cmd_i.side]) ? UW'(cmd_i.depth)
                                                       : used_q[cmd_i.side];
    ins_pos = iset_q ? ipos_q : lused;
    newf    = {1'b0, orec_q.filled} + {1'b0, cmd_q.qty};
    over    = newf > {1'b0, orec_q.size};
    done    = (newf[31:0] == orec_q.size);
    rem     = (orec_q.size >= orec_q.filled) ? orec_q.size - orec_q.filled : '0;
    addsum  = {1'b0, ltot_q} + {1'b0, cmd_q.qty};
    sattot  = addsum[32] ? '1 : addsum[31:0];
    newtot  = (ltot_q > tq_q) ? ltot_q - tq_q : '0;
    newcnt  = (drop_q && (lcnt_q != '0)) ? lcnt_q - NW'(1) : lcnt_q;
    beats   = lside_q ? (lvl_rd_q.price < lprice_q) : (lvl_rd_q.price > lprice_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lob_pkg::S_CLEAR:
        if (cnt_q == CW'(lob_pkg::ORDER_SLOTS - 1)) state_d = lob_pkg::S_IDLE;
      lob_pkg::S_IDLE:
        if (cmd_valid_i) begin
          case (cmd_i.kind) inside
            lob_pkg::K_ADD, lob_pkg::K_CANCEL, lob_pkg::K_FILL: state_d = lob_pkg::S_OSCAN;
            lob_pkg::K_QUERY: state_d = lob_pkg::S_LSCAN;
            lob_pkg::K_SNAP:  state_d = (snap_n == '0) ? lob_pkg::S_EMIT : lob_pkg::S_SNAP;
            default:          state_d = lob_pkg::S_EMIT;
          endcase
        end
      lob_pkg::S_OSCAN:
        if (cnt_q == CW'(lob_pkg::ORDER_SLOTS) && !pv_q) state_d = lob_pkg::S_ODEC;
      lob_pkg::S_ODEC:
        case (cmd_q.kind)
          lob_pkg::K_ADD:
            state_d = (hit_q || !free_q) ? lob_pkg::S_EMIT : lob_pkg::S_LSCAN;
          lob_pkg::K_FILL:
            state_d = (!hit_q || over) ? lob_pkg::S_EMIT : lob_pkg::S_LSCAN;
          default:
            state_d = !hit_q ? lob_pkg::S_EMIT : lob_pkg::S_LSCAN;
        endcase
      lob_pkg::S_LSCAN:
        if (cnt_q == CW'(lused) && !pv_q) state_d = lob_pkg::S_LDEC;
      lob_pkg::S_LDEC:
        case (cmd_q.kind)
          lob_pkg::K_QUERY: state_d = lob_pkg::S_EMIT;
          lob_pkg::K_ADD:
            if (lhit_q) state_d = lob_pkg::S_BEST0;
            else if (lused == UW'(lob_pkg::LEVEL_SLOTS)) state_d = lob_pkg::S_EMIT;
            else state_d = lob_pkg::S_SHIFT;
          default:
            state_d = (lhit_q && newcnt == '0) ? lob_pkg::S_SHIFT : lob_pkg::S_BEST0;
        endcase
      lob_pkg::S_SHIFT:
        if (mv_q == '0 && !pv_q) state_d = dir_up_q ? lob_pkg::S_LINS : lob_pkg::S_BEST0;
      lob_pkg::S_LINS:  state_d = lob_pkg::S_BEST0;
      lob_pkg::S_BEST0: state_d = lob_pkg::S_BEST1;
      lob_pkg::S_BEST1: state_d = lob_pkg::S_BEST2;
      lob_pkg::S_BEST2: state_d = lob_pkg::S_EMIT;
      lob_pkg::S_EMIT:  state_d = lob_pkg::S_IDLE;
      lob_pkg::S_SNAP:
        if (cnt_q == CW'(n_q) && !pv_q) state_d = lob_pkg::S_IDLE;
      default: state_d = lob_pkg::S_IDLE;
    endcase
  end

  // Memory ports and strobes.
  always_comb begin
    ow_en     = 1'b0;
    ow_addr   = hit_idx_q;
    ow_data   = orec_q;
    lw_en     = 1'b0;
    lw_addr   = {lside_q, lidx_q};
    lw_data   = '{price: lprice_q, total: newtot, count: newcnt};
    ord_ra    = cnt_q[OW-1:0];
    lvl_ra    = {lside_q, cnt_q[LW-1:0]};
    issue     = 1'b0;
    issue_idx = cnt_q[OW-1:0];
    emit      = 1'b0;
    unique case (state_q)
      lob_pkg::S_CLEAR: begin
        ow_en   = 1'b1;
        ow_addr = cnt_q[OW-1:0];
        ow_data = '0;
      end
      lob_pkg::S_OSCAN:
        issue = (cnt_q < CW'(lob_pkg::ORDER_SLOTS));
      lob_pkg::S_ODEC:
        if (hit_q && cmd_q.kind == lob_pkg::K_CANCEL) begin
          ow_en        = 1'b1;
          ow_data.used = 1'b0;
        end else if (hit_q && cmd_q.kind == lob_pkg::K_FILL && !over) begin
          ow_en          = 1'b1;
          ow_data.used   = !done;
          ow_data.filled = newf[31:0];
        end
      lob_pkg::S_LSCAN:
        issue = (cnt_q < CW'(lused));
      lob_pkg::S_LDEC: begin
        ow_addr = free_idx_q;
        ow_data = '{used: 1'b1, key: cmd_q.key, side: cmd_q.side, price: cmd_q.price,
                    size: cmd_q.qty, filled: '0};
        if (cmd_q.kind == lob_pkg::K_ADD) begin
          ow_en = lhit_q || (lused != UW'(lob_pkg::LEVEL_SLOTS));
          if (lhit_q) begin
            lw_en   = 1'b1;
            lw_data = '{price: lprice_q, total: sattot, count: lcnt_q + NW'(1)};
          end
        end else if (cmd_q.kind == lob_pkg::K_CANCEL || cmd_q.kind == lob_pkg::K_FILL) begin
          lw_en = lhit_q && (newcnt != '0);
        end
      end
      lob_pkg::S_SHIFT: begin
        issue     = (mv_q != '0);
        issue_idx = OW'(src_q);
        lvl_ra    = {lside_q, src_q[LW-1:0]};
        lw_en     = pv_q;
        lw_addr   = dir_up_q ? {lside_q, pidx_q[LW-1:0] + LW'(1)}
                             : {lside_q, pidx_q[LW-1:0] - LW'(1)};
        lw_data   = lvl_rd_q;
      end
      lob_pkg::S_LINS: begin
        lw_en   = 1'b1;
        lw_addr = {lside_q, ipos_q[LW-1:0]};
        lw_data = '{price: lprice_q, total: cmd_q.qty, count: NW'(1)};
      end
      lob_pkg::S_BEST0: lvl_ra = '0;
      lob_pkg::S_BEST1: lvl_ra = {1'b1, LW'(0)};
      lob_pkg::S_EMIT:  emit = 1'b1;
      lob_pkg::S_SNAP: begin
        issue  = (cnt_q < CW'(n_q));
        lvl_ra = {cmd_q.side, cnt_q[LW-1:0]};
        emit   = pv_q;
      end
      default: ;
    endcase
  end

  assign stat_o.pop      = (state_q == lob_pkg::S_IDLE) && cmd_valid_i;
  assign stat_o.clearing = (state_q == lob_pkg::S_CLEAR);

  // Table memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (ow_en) ord_mem[ow_addr] <= ow_data;
    ord_rd_q <= ord_mem[ord_ra];
    if (lw_en) lvl_mem[lw_addr] <= lw_data;
    lvl_rd_q <= lvl_mem[lvl_ra];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lob_pkg::S_CLEAR;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      used_q[0] <= '0;
      used_q[1] <= '0;
      bid_q     <= '0;
      ask_q     <= '0;
      res_v_q   <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      lhit_q    <= 1'b0;
      iset_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;
      res_v_q <= emit;
      case (state_q)
        lob_pkg::S_CLEAR: cnt_q <= cnt_q + CW'(1);
        lob_pkg::S_IDLE: begin
          cnt_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          lhit_q <= 1'b0;
          iset_q <= 1'b0;
        end
        lob_pkg::S_OSCAN: begin
          if (issue) cnt_q <= cnt_q + CW'(1);
          if (pv_q && ord_rd_q.used && ord_rd_q.key == cmd_q.key) hit_q <= 1'b1;
          if (pv_q && !ord_rd_q.used) free_q <= 1'b1;
        end
        lob_pkg::S_ODEC: cnt_q <= '0;
        lob_pkg::S_LSCAN: begin
          if (issue) cnt_q <= cnt_q + CW'(1);
          if (pv_q && lvl_rd_q.price == lprice_q) lhit_q <= 1'b1;
          if (pv_q && !beats) iset_q <= 1'b1;
        end
        lob_pkg::S_SHIFT:
          if (mv_q == '0 && !pv_q && !dir_up_q) used_q[lside_q] <= lused - UW'(1);
        lob_pkg::S_LINS: used_q[lside_q] <= lused + UW'(1);
        lob_pkg::S_BEST1: bid_q <= (used_q[0] != '0) ? lvl_rd_q.price : '0;
        lob_pkg::S_BEST2: ask_q <= (used_q[1] != '0) ? lvl_rd_q.price : '0;
        lob_pkg::S_SNAP: if (issue) cnt_q <= cnt_q + CW'(1);
        default: ;
      endcase
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk_i) begin
    pidx_q <= issue_idx;
    case (state_q)
      lob_pkg::S_IDLE:
        if (cmd_valid_i) begin
          cmd_q    <= cmd_i;
          status_q <= lob_pkg::ST_OK;
          lq_q     <= '0;
          lside_q  <= cmd_i.side;
          lprice_q <= cmd_i.price;
          n_q      <= snap_n;
        end
      lob_pkg::S_OSCAN: begin
        if (pv_q && ord_rd_q.used && ord_rd_q.key == cmd_q.key && !hit_q) begin
          hit_idx_q <= pidx_q;
          orec_q    <= ord_rd_q;
        end
        if (pv_q && !ord_rd_q.used && !free_q) free_idx_q <= pidx_q;
      end
      lob_pkg::S_ODEC:
        case (cmd_q.kind)
          lob_pkg::K_ADD:
            if (hit_q) status_q <= lob_pkg::ST_DUP;
            else if (!free_q) status_q <= lob_pkg::ST_OFULL;
          lob_pkg::K_FILL: begin
            if (!hit_q) status_q <= lob_pkg::ST_UNKNOWN;
            else if (over) status_q <= lob_pkg::ST_OVERFILL;
            tq_q     <= cmd_q.qty;
            drop_q   <= done;
            lside_q  <= orec_q.side;
            lprice_q <= orec_q.price;
          end
          default: begin
            if (!hit_q) status_q <= lob_pkg::ST_UNKNOWN;
            tq_q     <= rem;
            drop_q   <= 1'b1;
            lside_q  <= orec_q.side;
            lprice_q <= orec_q.price;
          end
        endcase
      lob_pkg::S_LSCAN: begin
        if (pv_q && lvl_rd_q.price == lprice_q && !lhit_q) begin
          lidx_q <= pidx_q[LW-1:0];
          ltot_q <= lvl_rd_q.total;
          lcnt_q <= lvl_rd_q.count;
        end
        if (pv_q && !beats && !iset_q) ipos_q <= UW'(pidx_q);
      end
      lob_pkg::S_LDEC: begin
        if (cmd_q.kind == lob_pkg::K_QUERY) lq_q <= lhit_q ? ltot_q : '0;
        if (cmd_q.kind == lob_pkg::K_ADD && !lhit_q &&
            lused == UW'(lob_pkg::LEVEL_SLOTS)) status_q <= lob_pkg::ST_LFULL;
        if (cmd_q.kind == lob_pkg::K_ADD) begin
          dir_up_q <= 1'b1;
          ipos_q   <= ins_pos;
          mv_q     <= lused - ins_pos;
          src_q    <= lused - UW'(1);
        end else begin
          dir_up_q <= 1'b0;
          mv_q     <= lused - UW'(1) - UW'(lidx_q);
          src_q    <= UW'(lidx_q) + UW'(1);
        end
      end
      lob_pkg::S_SHIFT:
        if (issue) begin
          mv_q  <= mv_q - UW'(1);
          src_q <= dir_up_q ? src_q - UW'(1) : src_q + UW'(1);
        end
      default: ;
    endcase

    // Result word.
    if (emit) begin
      o_bid_q <= bid_q;
      o_ask_q <= ask_q;
      o_mid_q <= {1'b0, bid_q} + {1'b0, ask_q};
      if (state_q == lob_pkg::S_SNAP) begin
        o_status_q <= lob_pkg::ST_OK;
        o_lq_q     <= '0;
        o_ev_q     <= 1'b1;
        o_eprice_q <= lvl_rd_q.price;
        o_eqty_q   <= lvl_rd_q.total;
        o_last_q   <= (CW'(pidx_q) + CW'(1)) == CW'(n_q);
      end else begin
        o_status_q <= status_q;
        o_lq_q     <= lq_q;
        o_ev_q     <= 1'b0;
        o_eprice_q <= '0;
        o_eqty_q   <= '0;
        o_last_q   <= 1'b1;
      end
    end
  end

  assign res_valid_o      = res_v_q;
  assign status_o         = o_status_q;
  assign best_bid_o       = o_bid_q;
  assign best_ask_o       = o_ask_q;
  assign mid_sum_o        = o_mid_q;
  assign level_quantity_o = o_lq_q;
  assign entry_valid_o    = o_ev_q;
  assign entry_price_o    = o_eprice_q;
  assign entry_quantity_o = o_eqty_q;
  assign last_o           = o_last_q;

endmodule
`default_nettype wire

// ===== design/limit_order_book.sv =====
// Price-level limit order book. Commands are taken on start while busy is low
// and wait in a two-entry queue; results come one per cycle on result_valid_o
// and cannot be held off. After reset the order table is swept clear with busy
// high. An add, cancel or fill scans the whole order table, then, unless it is
// refused, the side's level table, shifts the levels behind an inserted or
// removed one and rereads both best prices. A level query scans the side's
// level table; a depth snapshot reads one level per returned entry. Each table
// memory has a single read port, so the tables are walked one entry at a time.
`default_nettype none
module limit_order_book (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  opcode_i,
  input  wire logic [31:0]                 order_key_i,
  input  wire logic                        side_i,
  input  wire logic [31:0]                 price_i,
  input  wire logic [31:0]                 quantity_i,
  input  wire logic [lob_pkg::DEPTH_W-1:0] depth_i,
  output logic                             result_valid_o,
  output logic [2:0]                       status_o,
  output logic [31:0]                      best_bid_o,
  output logic [31:0]                      best_ask_o,
  output logic [32:0]                      mid_sum_o,
  output logic [31:0]                      level_quantity_o,
  output logic                             entry_valid_o,
  output logic [31:0]                      entry_price_o,
  output logic [31:0]                      entry_quantity_o,
  output logic                             last_o
);

  lob_pkg::cmd_t       cmd;
  logic                cmd_valid;
  lob_pkg::back_stat_t stat;

  // Front end: accepts and classifies commands.
  lob_front u_front (
    .clk_i, .rst_ni, .start, .busy,
    .opcode_i, .order_key_i, .side_i, .price_i, .quantity_i, .depth_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .stat_i(stat)
  );

  // Back end: walks the tables and produces results.
  lob_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .stat_o(stat),
    .res_valid_o(result_valid_o), .status_o, .best_bid_o, .best_ask_o,
    .mid_sum_o, .level_quantity_o, .entry_valid_o, .entry_price_o,
    .entry_quantity_o, .last_o
  );

  // A result word without an entry always closes its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !entry_valid_o |-> last_o)
    else $error("result without entry is not last");

  // Mid sum follows the reported best prices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> mid_sum_o == ({1'b0, best_bid_o} + {1'b0, best_ask_o}))
    else $error("mid sum mismatch");

  // Snapshot words carry no error status and no level quantity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && entry_valid_o |-> status_o == lob_pkg::ST_OK && level_quantity_o == '0)
    else $error("snapshot word with status");

endmodule
`default_nettype wire
